[design/r2y_pkg.sv]
// Shared constants, payload types and register indexes of the RGB to YUV 4:2:0 converter.
package r2y_pkg;

   // Frame size limits
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   // Counter and dimension widths
   localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
   localparam int BCOL_W = (COL_W > 1) ? COL_W - 1 : 1;
   localparam int BROW_W = (ROW_W > 1) ? ROW_W - 1 : 1;

   // Line store of even-row pair sums, one entry per block column
   localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Queues
   localparam int MID_DEPTH  = 4;
   localparam int MID_AW     = $clog2(MID_DEPTH);
   localparam int MID_CW     = $clog2(MID_DEPTH + 1);
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

   // Configuration port
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

   localparam int CHROMA_POS_W = 11;

   // Input request payload
   typedef struct packed {
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [7:0]              luma;
      logic                    chroma_valid;
      logic [7:0]              u_value;
      logic [7:0]              v_value;
      logic [CHROMA_POS_W-1:0] chroma_col;
      logic [CHROMA_POS_W-1:0] chroma_row;
      logic                    end_of_frame;
   } rsp_type;

   // Running R, G, B sums of a horizontal pair, 9 bits each
   typedef struct packed {
      logic [8:0] red;
      logic [8:0] green;
      logic [8:0] blue;
   } sums_type;

   // Classified pixel handed from front to back
   typedef struct packed {
      req_type           pixel;
      logic              col_odd;
      logic              row_odd;
      logic              last_col;
      logic              last_row;
      logic [BCOL_W-1:0] block_col;
      logic [BROW_W-1:0] block_row;
   } item_type;

endpackage

[design/r2y_front.sv]
// Front end: frame size registers, raster position counters and the request queue to the back end.
module r2y_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  r2y_pkg::req_type                 req_data,
   output logic                             req_full,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [r2y_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [r2y_pkg::CFG_W-1:0]        csr_wdata,
   output logic                             item_valid,
   output r2y_pkg::item_type                item_data,
   input  logic                             item_pop
);

   logic [r2y_pkg::CFG_W-1:0]  frame_width_ff, frame_width_in;
   logic [r2y_pkg::CFG_W-1:0]  frame_height_ff, frame_height_in;
   logic [r2y_pkg::COL_W-1:0]  col_ff, col_in;
   logic [r2y_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [r2y_pkg::MID_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [r2y_pkg::MID_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [r2y_pkg::MID_CW-1:0] count_ff, count_in;
   r2y_pkg::item_type          queue_mem [r2y_pkg::MID_DEPTH];

   logic                        accept;
   logic                        csr_write;
   logic [r2y_pkg::WDIM_W-1:0]  width_eff;
   logic [r2y_pkg::HDIM_W-1:0]  height_eff;
   logic                        last_col;
   logic                        last_row;
   r2y_pkg::item_type           new_item;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_full   = (count_ff == r2y_pkg::MID_CW'(r2y_pkg::MID_DEPTH));
   assign accept     = req_push && !req_full;
   assign item_valid = (count_ff != '0);
   assign item_data  = queue_mem[rd_ptr_ff];

   // Effective frame size: zero acts as one, oversize clips to the maximum
   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = r2y_pkg::WDIM_W'(1);
      end else if (32'(frame_width_ff) > r2y_pkg::MAX_WIDTH) begin
         width_eff = r2y_pkg::WDIM_W'(r2y_pkg::MAX_WIDTH);
      end else begin
         width_eff = r2y_pkg::WDIM_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_eff = r2y_pkg::HDIM_W'(1);
      end else if (32'(frame_height_ff) > r2y_pkg::MAX_HEIGHT) begin
         height_eff = r2y_pkg::HDIM_W'(r2y_pkg::MAX_HEIGHT);
      end else begin
         height_eff = r2y_pkg::HDIM_W'(frame_height_ff);
      end
   end

   // Position classification; a counter at or past the edge counts as the last one
   assign last_col = (r2y_pkg::WDIM_W'(col_ff) + r2y_pkg::WDIM_W'(1)) >= width_eff;
   assign last_row = (r2y_pkg::HDIM_W'(row_ff) + r2y_pkg::HDIM_W'(1)) >= height_eff;

   always_comb begin
      new_item.pixel     = req_data;
      new_item.col_odd   = col_ff[0];
      new_item.row_odd   = row_ff[0];
      new_item.last_col  = last_col;
      new_item.last_row  = last_row;
      new_item.block_col = r2y_pkg::BCOL_W'(col_ff >> 1);
      new_item.block_row = r2y_pkg::BROW_W'(row_ff >> 1);
   end

   // Configuration register writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         case (csr_index)
            r2y_pkg::REG_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            r2y_pkg::REG_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + r2y_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + r2y_pkg::COL_W'(1);
         end
      end
   end

   // Queue pointers
   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + r2y_pkg::MID_AW'(1) : wr_ptr_ff;
      rd_ptr_in = item_pop ? rd_ptr_ff + r2y_pkg::MID_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + r2y_pkg::MID_CW'(accept) - r2y_pkg::MID_CW'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= r2y_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= r2y_pkg::FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         count_ff        <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (accept) begin
         queue_mem[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[design/r2y_back.sv]
// Back end: pair accumulation, even-row line store, luma and chroma math, result queue.
module r2y_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  r2y_pkg::item_type item_data,
   output logic              item_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output r2y_pkg::rsp_type  rsp_data
);

   // Stage 1 and 2 control and payload
   typedef struct packed {
      logic                              chroma_valid;
      logic                              col_odd;
      logic                              row_odd;
      logic                              end_of_frame;
      logic [r2y_pkg::CHROMA_POS_W-1:0]  chroma_col;
      logic [r2y_pkg::CHROMA_POS_W-1:0]  chroma_row;
      logic [7:0]                        luma;
   } stage_type;

   logic                         pair_we;
   logic                         v1_ff, v1_in, v2_ff, v2_in;
   stage_type                    s1_ff, s1_in, s2_ff, s2_in;
   r2y_pkg::sums_type            pair_ff, pair_in;
   r2y_pkg::sums_type            pair1_ff;
   r2y_pkg::sums_type            line_rd_ff;
   r2y_pkg::sums_type            line_mem [r2y_pkg::STORE_DEPTH];
   logic [7:0]                   avg_r_ff, avg_g_ff, avg_b_ff;
   logic [7:0]                   avg_r_in, avg_g_in, avg_b_in;
   logic [r2y_pkg::OUTQ_AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [r2y_pkg::OUTQ_CW-1:0]  count_ff, count_in;
   r2y_pkg::rsp_type             outq_mem [r2y_pkg::OUTQ_DEPTH];

   logic [r2y_pkg::OUTQ_CW:0]    in_flight;
   logic                         go;
   logic                         store_wr;
   logic [r2y_pkg::STORE_AW-1:0] store_addr;
   logic [15:0]                  luma_sum;
   logic [1:0]                   shift_amt;
   logic [16:0]                  u_sum, v_sum;
   r2y_pkg::rsp_type             result;
   logic                         out_pop;

   // Block average: sum of up to four samples divided by 1, 2 or 4, clipped to 8 bits
   function automatic logic [7:0] block_avg(input logic [9:0] sum, input logic [1:0] sh);
      logic [9:0] q;
      q = sum >> sh;
      return (q > 10'd255) ? 8'd255 : q[7:0];
   endfunction

   // Take an item only when the result queue has room for everything in flight
   assign in_flight = (r2y_pkg::OUTQ_CW + 1)'(v1_ff) + (r2y_pkg::OUTQ_CW + 1)'(v2_ff)
                    + (r2y_pkg::OUTQ_CW + 1)'(count_ff);
   assign go        = item_valid && (in_flight < (r2y_pkg::OUTQ_CW + 1)'(r2y_pkg::OUTQ_DEPTH));
   assign item_pop  = go;

   // Stage 0: pair sums, luma, line store access
   assign pair_we    = go;
   assign store_addr = r2y_pkg::STORE_AW'(item_data.block_col);
   assign store_wr   = go && (item_data.col_odd || item_data.last_col)
                     && !item_data.row_odd && !item_data.last_row;
   assign luma_sum   = 16'(66 * item_data.pixel.red_in) + 16'(129 * item_data.pixel.green_in)
                     + 16'(25 * item_data.pixel.blue_in) + 16'd128;

   always_comb begin
      pair_in = pair_ff;
      if (pair_we) begin
         if (item_data.col_odd) begin
            pair_in.red   = pair_ff.red   + 9'(item_data.pixel.red_in);
            pair_in.green = pair_ff.green + 9'(item_data.pixel.green_in);
            pair_in.blue  = pair_ff.blue  + 9'(item_data.pixel.blue_in);
         end else begin
            pair_in.red   = 9'(item_data.pixel.red_in);
            pair_in.green = 9'(item_data.pixel.green_in);
            pair_in.blue  = 9'(item_data.pixel.blue_in);
         end
      end
   end

   always_comb begin
      v1_in              = go;
      s1_in.chroma_valid = (item_data.col_odd || item_data.last_col)
                         && (item_data.row_odd || item_data.last_row);
      s1_in.col_odd      = item_data.col_odd;
      s1_in.row_odd      = item_data.row_odd;
      s1_in.end_of_frame = item_data.last_col && item_data.last_row;
      s1_in.chroma_col   = r2y_pkg::CHROMA_POS_W'(item_data.block_col);
      s1_in.chroma_row   = r2y_pkg::CHROMA_POS_W'(item_data.block_row);
      s1_in.luma         = luma_sum[15:8] + 8'd16;
   end

   // Stage 1: add the even-row pair and divide by the sample count
   assign shift_amt = 2'(s1_ff.col_odd) + 2'(s1_ff.row_odd);

   always_comb begin
      logic [9:0] sr, sg, sb;
      sr = 10'(pair1_ff.red);
      sg = 10'(pair1_ff.green);
      sb = 10'(pair1_ff.blue);
      if (s1_ff.row_odd) begin
         sr = sr + 10'(line_rd_ff.red);
         sg = sg + 10'(line_rd_ff.green);
         sb = sb + 10'(line_rd_ff.blue);
      end
      avg_r_in = block_avg(sr, shift_amt);
      avg_g_in = block_avg(sg, shift_amt);
      avg_b_in = block_avg(sb, shift_amt);
      v2_in    = v1_ff;
      s2_in    = s1_ff;
   end

   // Stage 2: chroma; both sums stay within 0..65535 for 8-bit averages
   assign u_sum = 17'(112 * avg_b_ff) + 17'd32896 - 17'(38 * avg_r_ff) - 17'(74 * avg_g_ff);
   assign v_sum = 17'(112 * avg_r_ff) + 17'd32896 - 17'(94 * avg_g_ff) - 17'(18 * avg_b_ff);

   always_comb begin
      result.luma         = s2_ff.luma;
      result.chroma_valid = s2_ff.chroma_valid;
      result.end_of_frame = s2_ff.end_of_frame;
      if (s2_ff.chroma_valid) begin
         result.u_value    = u_sum[15:8];
         result.v_value    = v_sum[15:8];
         result.chroma_col = s2_ff.chroma_col;
         result.chroma_row = s2_ff.chroma_row;
      end else begin
         result.u_value    = '0;
         result.v_value    = '0;
         result.chroma_col = '0;
         result.chroma_row = '0;
      end
   end

   // Result queue
   assign rsp_empty = (count_ff == '0);
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_data  = outq_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = v2_ff ? wr_ptr_ff + r2y_pkg::OUTQ_AW'(1) : wr_ptr_ff;
      rd_ptr_in = out_pop ? rd_ptr_ff + r2y_pkg::OUTQ_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + r2y_pkg::OUTQ_CW'(v2_ff) - r2y_pkg::OUTQ_CW'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         pair_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         pair_ff   <= pair_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      s1_ff    <= s1_in;
      pair1_ff <= pair_in;
      s2_ff    <= s2_in;
      avg_r_ff <= avg_r_in;
      avg_g_ff <= avg_g_in;
      avg_b_ff <= avg_b_in;
   end

   // Line store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (store_wr) begin
         line_mem[store_addr] <= pair_in;
      end
      if (go) begin
         line_rd_ff <= line_mem[store_addr];
      end
   end

   // Result queue storage
   always_ff @(posedge clock) begin
      if (v2_ff) begin
         outq_mem[wr_ptr_ff] <= result;
      end
   end

endmodule

[design/rgb_to_yuv420_converter.sv]
// Top level of the RGB to YUV 4:2:0 converter.
// Takes one pixel per clock in raster order while req_full is low and returns one result per
// pixel, in order: the BT.601 limited-range luma of that pixel and, on the pixel that closes a
// 2x2 block or a smaller edge block, the U/V pair of the block with its block column and row.
// The back end reads a pixel pushed into an idle block straight out of the front queue, and two
// pipeline registers and the result queue write follow. The back end takes a new pixel every
// cycle as long as its 4-entry result queue can hold all results in flight, so the sustained
// rate is one pixel per clock while results are popped. The user must write frame width and
// height through the csr port only while the block is idle; the block does not enforce it.
// 0 acts as 1 and values above 4096 act as 4096. The line store needs no clearing after reset.
module rgb_to_yuv420_converter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  r2y_pkg::req_type              req_data,
   output logic                          req_full,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output r2y_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [r2y_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [r2y_pkg::CFG_W-1:0]     csr_wdata
);

   logic              item_valid;
   logic              item_pop;
   r2y_pkg::item_type item_data;

   // Position tracking and request queue
   r2y_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_pop   (item_pop)
   );

   // Conversion pipeline and result queue
   r2y_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_pop   (item_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
